/* hdl/pmai_pkg.sv */
// ----------------------------------------------------------------------------
// pmai_pkg: shared types and constants of the path mileage interpolator
// Table geometry, entry layout, register indexes and controller states.
// ----------------------------------------------------------------------------
package pmai_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int MIL_W   = 40;
	localparam int IN_W    = 208;
	localparam int OUT_W   = 136;
	localparam int ENTRY_W = 136;

	localparam logic [1:0] CFG_START_MILEAGE = 2'd0;
	localparam logic [1:0] CFG_ATTR_MODE     = 2'd1;
	localparam logic [1:0] CFG_TABLE_ENTRIES = 2'd2;

	localparam logic signed [MIL_W-1:0] MILEAGE_MAX = {1'b0, {(MIL_W-1){1'b1}}};

	// One table entry; mileage sits in the lowest bits, speed limit in the highest.
	typedef struct packed {
		logic [15:0]             speed_limit;
		logic [7:0]              right_type;
		logic [7:0]              left_type;
		logic [15:0]             right_width;
		logic [15:0]             left_width;
		logic signed [31:0]      height;
		logic signed [MIL_W-1:0] mileage;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQS,
		ST_ROOT,
		ST_SUM,
		ST_POST,
		ST_FIRST,
		ST_LAST,
		ST_CHKB,
		ST_GOTA,
		ST_FIELD,
		ST_ML,
		ST_MH,
		ST_MA,
		ST_DIV,
		ST_APPLY,
		ST_EMIT
	} state_t;

endpackage

/* hdl/pmai_ram.sv */
// ----------------------------------------------------------------------------
// pmai_ram: generic simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pmai_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/path_mileage_attribute_interpolator.sv */
// ----------------------------------------------------------------------------
// path_mileage_attribute_interpolator: path mileage and road attribute lookup
// Accumulates arc length over streamed path points and interpolates road
// attributes from a loaded, mileage-sorted table.
// ----------------------------------------------------------------------------
// Usage. The slave channel (s_tvalid/s_tready/s_tdata/s_tuser) carries two
// kinds of item, chosen by s_tuser[0]. A load item writes one table entry at
// entry_index in its accept cycle and gives no result. A point item gives at
// most one result on the master channel (m_tvalid/m_tready/m_tdata/m_tuser).
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and must only be written while no point is in flight.
// Processing. A first point in mileage-only mode gives its result without a
// distance step. A later point forms the squared distance on the shared
// multiplier and takes its square root in a bit-serial loop before the result
// is added to the mileage. In attribute
// mode the table lookup adds RAM reads, and in an interpolated
// point each of the height and width fields may run a
// multiply in low and high halves and a restoring division through the same serial
// unit. One point is processed at a time.
// Reset clears the position, mileage and segment index; table contents are
// undefined until loaded. When the receiver stalls, the finished result waits
// in the output register; the next item is accepted meanwhile, but a second
// result holds the controller until the first one is taken.
// ----------------------------------------------------------------------------
module path_mileage_attribute_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata, low to high: entry_index, x_mm, y_mm, entry_mileage, entry_height,
	// entry_left_width, entry_right_width, entry_left_type, entry_right_type,
	// entry_speed_limit, zero fill
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [pmai_pkg::IN_W-1:0] s_tdata,
	// s_tuser, low to high: req_type, path_start
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, low to high: mileage, height, left_width, right_width,
	// left_type, right_type, speed_limit
	output logic [pmai_pkg::OUT_W-1:0] m_tdata,
	// m_tuser: attributes_valid
	output logic [0:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data
);
	import pmai_pkg::*;

	// Unpacked input fields.
	logic                    in_req_type, in_first;
	logic [5:0]              in_entry_index;
	logic signed [30:0]      in_x, in_y;
	entry_t                  in_entry;

	assign in_req_type    = s_tuser[0];
	assign in_first       = s_tuser[1];
	assign in_entry_index = s_tdata[5:0];
	assign in_x           = s_tdata[36:6];
	assign in_y           = s_tdata[67:37];
	assign in_entry       = entry_t'(s_tdata[203:68]);

	// Configuration registers.
	logic signed [MIL_W-1:0] start_q;
	logic                    mode_q;
	logic [6:0]              tbl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			mode_q  <= 1'b0;
			tbl_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_MILEAGE: start_q <= cfg_data;
				CFG_ATTR_MODE:     mode_q  <= cfg_data[0];
				CFG_TABLE_ENTRIES: tbl_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// Table RAM: a load item writes in its accept cycle.
	logic             ram_we;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           rd;
	logic [ENTRY_W-1:0] ram_rdata;

	assign ram_we = in_acc && !in_req_type && (int'(in_entry_index) < TABLE_DEPTH);
	assign rd     = entry_t'(ram_rdata);

	pmai_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IDX_W'(in_entry_index)),
		.wdata(ENTRY_W'(in_entry)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Point state and datapath registers.
	logic signed [30:0]      lx_q, ly_q;
	logic signed [MIL_W-1:0] run_q, s_q;
	logic [IDX_W-1:0]        seg_q;
	logic                    first_q;
	logic [31:0]             dx_q, dy_q;
	logic [65:0]             prod_q;
	logic [74:0]             acc_q;
	logic [63:0]             res_q;
	logic [6:0]              cnt_q;
	logic [42:0]             rem_q;
	logic [39:0]             quo_q;
	logic                    big_q;
	entry_t                  ea_q, eb_q, rs_q;
	logic                    rattr_q;
	logic [40:0]             dtm_q, ddm_q;
	logic                    dtneg_q, ddneg_q, dtzero_q;
	logic [32:0]             dvm_q;
	logic signed [32:0]      v0_q;
	logic                    neg_q;
	logic [1:0]              fld_q;

	// Table bounds.
	logic [CNT_W-1:0] n_ent;
	logic [IDX_W-1:0] last_idx, a_cl;

	always_comb begin
		if (int'(tbl_q) > TABLE_DEPTH) begin
			n_ent = CNT_W'(TABLE_DEPTH);
		end else begin
			n_ent = CNT_W'(tbl_q);
		end
		last_idx = IDX_W'(n_ent - CNT_W'(1));
		if (seg_q > last_idx - IDX_W'(1)) begin
			a_cl = last_idx - IDX_W'(1);
		end else begin
			a_cl = seg_q;
		end
	end

	// Distance from the previous point.
	logic signed [31:0] xd, yd;
	assign xd = {in_x[30], in_x} - {lx_q[30], lx_q};
	assign yd = {in_y[30], in_y} - {ly_q[30], ly_q};

	// Shared multiplier operands.
	logic [32:0] mul_a, mul_b;
	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = {1'b0, dx_q};
				mul_b = {1'b0, dx_q};
			end
			ST_SQY: begin
				mul_a = {1'b0, dy_q};
				mul_b = {1'b0, dy_q};
			end
			ST_ML: begin
				mul_a = {1'b0, dtm_q[31:0]};
				mul_b = dvm_q;
			end
			ST_MH: begin
				mul_a = {24'b0, dtm_q[40:32]};
				mul_b = dvm_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Square root step.
	logic [63:0] sq_bit, sq_trial;
	assign sq_bit   = 64'(1) << {cnt_q[4:0], 1'b0};
	assign sq_trial = res_q + sq_bit;

	// Mileage sum with saturation; a negative running mileage never saturates.
	logic signed [MIL_W:0]   msum;
	logic signed [MIL_W-1:0] msat;
	assign msum = {run_q[MIL_W-1], run_q} + $signed({9'b0, res_q[31:0]});
	assign msat = (msum > $signed({1'b0, MILEAGE_MAX})) ? MILEAGE_MAX : msum[MIL_W-1:0];

	// Table entry as read, carrying the point's mileage.
	entry_t rd_m;
	always_comb begin
		rd_m         = rd;
		rd_m.mileage = s_q;
	end

	// Segment differences.
	logic signed [MIL_W:0] dt_w, dd_w;
	assign dt_w = {s_q[MIL_W-1], s_q} - {rd.mileage[MIL_W-1], rd.mileage};
	assign dd_w = {eb_q.mileage[MIL_W-1], eb_q.mileage} - {rd.mileage[MIL_W-1], rd.mileage};

	// Per-field end points.
	logic signed [32:0] f_v0, f_v1, f_dv;
	always_comb begin
		case (fld_q)
			2'd0: begin
				f_v0 = {ea_q.height[31], ea_q.height};
				f_v1 = {eb_q.height[31], eb_q.height};
			end
			2'd1: begin
				f_v0 = {17'b0, ea_q.left_width};
				f_v1 = {17'b0, eb_q.left_width};
			end
			default: begin
				f_v0 = {17'b0, ea_q.right_width};
				f_v1 = {17'b0, eb_q.right_width};
			end
		endcase
		f_dv = f_v1 - f_v0;
	end

	// Division step.
	logic [42:0] div_r;
	assign div_r = {rem_q[41:0], acc_q[73]};

	// Quotient application and clamping.
	logic [40:0]        qv;
	logic signed [42:0] v0x, rsum;
	logic signed [31:0] clamp_h;
	logic [15:0]        clamp_w;
	always_comb begin
		qv   = big_q ? 41'(1) << 40 : {1'b0, quo_q};
		v0x  = {{10{v0_q[32]}}, v0_q};
		rsum = neg_q ? v0x - $signed({2'b0, qv}) : v0x + $signed({2'b0, qv});
		if (rsum < -43'sd2147483648) begin
			clamp_h = 32'sh8000_0000;
		end else if (rsum > 43'sd2147483647) begin
			clamp_h = 32'sh7fff_ffff;
		end else begin
			clamp_h = rsum[31:0];
		end
		if (rsum < 43'sd0) begin
			clamp_w = 16'd0;
		end else if (rsum > 43'sd65535) begin
			clamp_w = 16'hffff;
		end else begin
			clamp_w = rsum[15:0];
		end
	end

	logic out_free;
	assign out_free = !m_tvalid || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_req_type) begin
					state_d = in_first ? ST_POST : ST_SQX;
				end
			end
			ST_SQX:  state_d = ST_SQY;
			ST_SQY:  state_d = ST_SQS;
			ST_SQS:  state_d = ST_ROOT;
			ST_ROOT: state_d = (cnt_q == '0) ? ST_SUM : ST_ROOT;
			ST_SUM:  state_d = ST_POST;
			ST_POST: begin
				if (!mode_q) begin
					state_d = ST_EMIT;
				end else if (n_ent == '0) begin
					state_d = ST_IDLE;
				end else if (first_q) begin
					state_d = ST_FIRST;
				end else begin
					state_d = ST_LAST;
				end
			end
			ST_FIRST: state_d = ST_EMIT;
			ST_LAST: begin
				if (n_ent == CNT_W'(1) || s_q >= rd.mileage) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_CHKB;
				end
			end
			ST_CHKB: state_d = (s_q >= rd.mileage) ? ST_EMIT : ST_GOTA;
			ST_GOTA: state_d = (eb_q.mileage == rd.mileage) ? ST_EMIT : ST_FIELD;
			ST_FIELD: begin
				if (dtzero_q || f_dv == '0) begin
					state_d = (fld_q == 2'd2) ? ST_EMIT : ST_FIELD;
				end else begin
					state_d = ST_ML;
				end
			end
			ST_ML:    state_d = ST_MH;
			ST_MH:    state_d = ST_MA;
			ST_MA:    state_d = ST_DIV;
			ST_DIV:   state_d = (cnt_q == '0) ? ST_APPLY : ST_DIV;
			ST_APPLY: state_d = (fld_q == 2'd2) ? ST_EMIT : ST_FIELD;
			ST_EMIT:  state_d = out_free ? ST_IDLE : ST_EMIT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_POST: ram_raddr = first_q ? '0 : last_idx;
			ST_LAST: ram_raddr = a_cl + IDX_W'(1);
			ST_CHKB: ram_raddr = seg_q;
			default: ram_raddr = seg_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lx_q    <= '0;
			ly_q    <= '0;
			run_q   <= '0;
			seg_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc && in_req_type) begin
				lx_q <= in_x;
				ly_q <= in_y;
				if (in_first) begin
					run_q <= start_q;
				end
			end
			case (state_q)
				ST_SUM:   run_q <= msat;
				ST_FIRST: seg_q <= '0;
				ST_LAST: begin
					// The segment index is only clamped when a segment is searched.
					if (!(n_ent == CNT_W'(1) || s_q >= rd.mileage)) begin
						seg_q <= a_cl;
					end
				end
				ST_CHKB: begin
					if (s_q >= rd.mileage) begin
						seg_q <= seg_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_req_type) begin
					first_q <= in_first;
					dx_q    <= xd[31] ? 32'(-xd) : 32'(xd);
					dy_q    <= yd[31] ? 32'(-yd) : 32'(yd);
					s_q     <= start_q;
				end
			end
			ST_SQY: acc_q <= 75'(prod_q);
			ST_SQS: begin
				acc_q <= acc_q + 75'(prod_q);
				res_q <= '0;
				cnt_q <= 7'd31;
			end
			ST_ROOT: begin
				if (acc_q[63:0] >= sq_trial) begin
					acc_q <= {11'b0, acc_q[63:0] - sq_trial};
					res_q <= (res_q >> 1) + sq_bit;
				end else begin
					res_q <= res_q >> 1;
				end
				cnt_q <= cnt_q - 7'd1;
			end
			ST_SUM: s_q <= msat;
			ST_POST: begin
				rs_q    <= entry_t'({{(ENTRY_W-MIL_W){1'b0}}, s_q});
				rattr_q <= mode_q;
			end
			ST_FIRST: rs_q <= rd_m;
			ST_LAST: begin
				if (n_ent == CNT_W'(1) || s_q >= rd.mileage) begin
					rs_q <= rd_m;
				end
			end
			ST_CHKB: begin
				eb_q <= rd;
				if (s_q >= rd.mileage) begin
					rs_q <= rd_m;
				end
			end
			ST_GOTA: begin
				ea_q     <= rd;
				rs_q     <= rd_m;
				dtzero_q <= (dt_w == '0);
				dtneg_q  <= dt_w[MIL_W];
				ddneg_q  <= dd_w[MIL_W];
				dtm_q    <= dt_w[MIL_W] ? 41'(-dt_w) : 41'(dt_w);
				ddm_q    <= dd_w[MIL_W] ? 41'(-dd_w) : 41'(dd_w);
				fld_q    <= 2'd0;
			end
			ST_FIELD: begin
				v0_q  <= f_v0;
				dvm_q <= f_dv[32] ? 33'(-f_dv) : 33'(f_dv);
				neg_q <= dtneg_q ^ f_dv[32] ^ ddneg_q;
				if (dtzero_q || f_dv == '0) begin
					fld_q <= fld_q + 2'd1;
				end
			end
			ST_MH: acc_q <= 75'(prod_q);
			ST_MA: begin
				acc_q <= acc_q + (75'(prod_q) << 32);
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				cnt_q <= 7'd73;
			end
			ST_DIV: begin
				if (div_r >= {2'b0, ddm_q}) begin
					rem_q <= div_r - {2'b0, ddm_q};
					if (cnt_q >= 7'd40) begin
						big_q <= 1'b1;
					end else begin
						quo_q[cnt_q[5:0]] <= 1'b1;
					end
				end else begin
					rem_q <= div_r;
				end
				acc_q <= acc_q << 1;
				cnt_q <= cnt_q - 7'd1;
			end
			ST_APPLY: begin
				case (fld_q)
					2'd0:    rs_q.height      <= clamp_h;
					2'd1:    rs_q.left_width  <= clamp_w;
					default: rs_q.right_width <= clamp_w;
				endcase
				fld_q <= fld_q + 2'd1;
			end
			default: ;
		endcase
	end

	// Output register; a skipped field keeps the lower entry's value already in rs_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata    <= OUT_W'(rs_q);
			m_tuser[0] <= rattr_q;
		end
	end

endmodule

/* hdl/pmai_checker.sv */
// ----------------------------------------------------------------------------
// pmai_checker: port-level checks of the path mileage interpolator
// Watches the stream and result ports over time.
// ----------------------------------------------------------------------------
module pmai_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [pmai_pkg::OUT_W-1:0] m_tdata,
	input logic [0:0]  m_tuser
);
	import pmai_pkg::*;

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// A point leaves the block busy in the cycle after it is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
		else $error("point accepted back to back");

	// A load item leaves the block ready for the next item.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> s_tready)
		else $error("load item stalled input");

	// Mileage-only results carry zero attribute fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[OUT_W-1:MIL_W] == '0)
		else $error("attribute fields set in mileage-only result");

endmodule

bind path_mileage_attribute_interpolator pmai_checker u_pmai_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
